### sv/gaussian_function_eval_assert.svh
// Assertion macros for the Gaussian evaluator checker.
`ifndef GAUSSIAN_FUNCTION_EVAL_ASSERT_SVH
`define GAUSSIAN_FUNCTION_EVAL_ASSERT_SVH
`define GFE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gfe check failed");
`define GFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gfe check failed");
`endif

### sv/gfe_pkg.sv
// Shared constants and helpers for the Gaussian evaluator.
package gfe_pkg;
   localparam int unsigned INV_W = 48;
   localparam int unsigned TERMS = 12;
   localparam int unsigned DATA_WIDTH = 32;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;
   localparam logic [1:0] REG_AMPLITUDE = 2'd0;
   localparam logic [1:0] REG_CENTER = 2'd1;
   localparam logic [1:0] REG_WIDTH = 2'd2;
   // 33-bit reciprocals of the Taylor divisors, Q1.32 rounded up
   function automatic logic [32:0] recip_n(input logic [3:0] n);
      logic [32:0] v;
      case (n)
         4'd1: v = 33'h1_0000_0000;
         4'd2: v = 33'h0_8000_0000;
         4'd3: v = 33'h0_5555_5556;
         4'd4: v = 33'h0_4000_0000;
         4'd5: v = 33'h0_3333_3334;
         4'd6: v = 33'h0_2AAA_AAAB;
         4'd7: v = 33'h0_2492_4925;
         4'd8: v = 33'h0_2000_0000;
         4'd9: v = 33'h0_1C71_C71D;
         4'd10: v = 33'h0_1999_999A;
         4'd11: v = 33'h0_1745_D175;
         4'd12: v = 33'h0_1555_5556;
         default: v = 33'h1_0000_0000;
      endcase
      return v;
   endfunction
endpackage

### sv/gaussian_function_eval.sv
// Gaussian bell evaluator: a*exp(-(x-b)^2/(2c^2)) in signed fixed point.
// One word can enter on every cycle while busy is low. Its result is on the
// rsp_ ports for one cycle, marked by rsp_valid; the receiver cannot stall it.
// The pipe stages are: difference, square, partial products, product sum,
// exponent check, ln2 reduction, Horner load, two stages per Taylor term,
// amplitude product and the output register. Writing width starts a
// bit-serial reciprocal of 2*FRAC_BITS+32 steps plus a rounding step;
// busy is high while they run (a zero width instead ends at the first step
// with an all-ones reciprocal) and no word is taken meanwhile.
module gaussian_function_eval #(
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic signed [31:0]    req_sample_x,
   output logic                  rsp_valid,
   output logic signed [31:0]    rsp_gauss_value,
   output logic                  rsp_saturated,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [3:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   import gfe_pkg::*;

   localparam int TOP = 31 + 2 * FRAC_BITS;
   localparam int CW = $clog2(TOP + 2);
   localparam int S2 = 2 * FRAC_BITS;
   localparam int ST = 8 + 2 * TERMS;
   localparam logic signed [63:0] MAXPOS = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;

   // ---------------- configuration ----------------
   logic signed [31:0] amp_ff, ctr_ff;
   logic [30:0] wid_ff;
   logic [INV_W-1:0] inv_ff;
   logic div_run_ff;
   logic [CW-1:0] div_cnt_ff;
   logic [63:0] div_rem_ff, div_den_ff;
   logic [63:0] div_q_ff;
   logic div_ovf_ff;
   logic wr;
   logic [1:0] widx;

   assign pready = 1'b1;
   assign wr = psel & penable & pwrite;
   assign widx = paddr[3:2];

   always_comb begin
      prdata = 32'd0;
      unique case (widx)
         REG_AMPLITUDE: prdata = amp_ff;
         REG_CENTER: prdata = ctr_ff;
         REG_WIDTH: prdata = {1'b0, wid_ff};
         default: prdata = 32'd0;
      endcase
   end

   logic [63:0] rem_sh;
   logic [63:0] rnd_q;
   assign rem_sh = {div_rem_ff[62:0], (div_cnt_ff == CW'(TOP))};

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff <= 32'sd65536;
         ctr_ff <= 32'sd0;
         wid_ff <= 31'(1 << FRAC_BITS);
         // reciprocal for a width of one
         inv_ff <= 48'h8000_0000;
         div_run_ff <= 1'b0;
         div_cnt_ff <= '0;
         div_rem_ff <= '0;
         div_den_ff <= '0;
         div_q_ff <= '0;
         div_ovf_ff <= 1'b0;
      end else begin
         if (wr && widx == REG_AMPLITUDE) amp_ff <= pwdata;
         if (wr && widx == REG_CENTER) ctr_ff <= pwdata;
         if (wr && widx == REG_WIDTH) begin
            wid_ff <= pwdata[30:0];
            div_den_ff <= 64'(pwdata[30:0]) * 64'(pwdata[30:0]);
            div_run_ff <= 1'b1;
            div_cnt_ff <= CW'(TOP);
            div_rem_ff <= '0;
            div_q_ff <= '0;
            div_ovf_ff <= 1'b0;
         end else if (div_run_ff) begin
            if (div_den_ff == 64'd0) begin
               inv_ff <= '1;
               div_run_ff <= 1'b0;
            end else begin
               if (rem_sh >= div_den_ff) begin
                  div_rem_ff <= rem_sh - div_den_ff;
                  if (div_cnt_ff >= CW'(48)) div_ovf_ff <= 1'b1;
                  else div_q_ff <= div_q_ff | (64'd1 << div_cnt_ff);
               end else begin
                  div_rem_ff <= rem_sh;
               end
               if (div_cnt_ff == '0) begin
                  div_run_ff <= 1'b0;
                  div_cnt_ff <= CW'(TOP + 1);
               end else begin
                  div_cnt_ff <= div_cnt_ff - 1'b1;
               end
            end
         end else if (div_cnt_ff == CW'(TOP + 1)) begin
            // final rounding step
            div_cnt_ff <= '0;
            if (div_ovf_ff || rnd_q > 64'hFFFF_FFFF_FFFF) inv_ff <= '1;
            else inv_ff <= rnd_q[INV_W-1:0];
         end
      end
   end
   assign rnd_q = div_q_ff + 64'(div_rem_ff >= div_den_ff - div_rem_ff);

   assign busy = div_run_ff | (div_cnt_ff == CW'(TOP + 1));

   // ---------------- pipeline ----------------
   logic [ST-1:0] v_ff;
   logic acc;
   assign acc = start & ~busy;

   // stage 0: difference, |x-b| fits in 32 bits
   logic [31:0] dm0_ff;
   logic neg0_ff;
   logic [31:0] am0_ff;
   logic signed [32:0] dif;
   assign dif = 33'(req_sample_x) - 33'(ctr_ff);
   // stage 1: square
   logic [63:0] sq1_ff;
   logic neg1_ff; logic [31:0] am1_ff;
   // stage 2/3: times reciprocal as four partial products, then their sum
   logic [63:0] pp00_ff, pp10_ff;
   logic [47:0] pp01_ff, pp11_ff;
   logic neg2_ff; logic [31:0] am2_ff;
   logic [113:0] prod3_ff;
   logic neg3_ff; logic [31:0] am3_ff;
   // stage 4/5: exponent, then reduction by ln2 via quotient estimate
   logic [37:0] e4_ff; logic ok4_ff;
   logic neg4_ff; logic [31:0] am4_ff;
   logic [5:0] k5_ff; logic [31:0] r5_ff; logic ok5_ff;
   logic neg5_ff; logic [31:0] am5_ff;

   logic [113:0] prod3;
   assign prod3 = 114'(pp00_ff) + (114'(pp01_ff) << 32) + (114'(pp10_ff) << 32)
                  + (114'(pp11_ff) << 64);
   logic [113:0] e_full;
   assign e_full = prod3_ff >> S2;

   // Horner stage registers
   logic [32:0] p_ff [TERMS+1];
   logic [31:0] r_ff [TERMS+1];
   logic [5:0]  k_ff [TERMS+1];
   logic ok_ff [TERMS+1];
   logic ng_ff [TERMS+1];
   logic [31:0] am_ff [TERMS+1];
   // mid-step registers: (r*p)>>32 and the side data
   logic [31:0] t_ff [TERMS];
   logic [31:0] rh_ff [TERMS];
   logic [5:0]  kh_ff [TERMS];
   logic okh_ff [TERMS];
   logic ngh_ff [TERMS];
   logic [31:0] amh_ff [TERMS];

   // k estimate: e/ln2 with e < 32*2^32, k < 47
   logic [5:0] kq;
   logic [37:0] kr;
   always_comb begin
      logic [37:0] rr;
      logic [5:0] q;
      rr = e4_ff;
      q = '0;
      for (int b = 5; b >= 0; b--) begin
         if (rr >= (38'(LN2_Q32) << b)) begin
            rr = rr - (38'(LN2_Q32) << b);
            q[b] = 1'b1;
         end
      end
      kq = q;
      kr = rr;
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else v_ff <= {v_ff[ST-2:0], acc};
      dm0_ff <= dif[32] ? 32'(-dif) : dif[31:0];
      am0_ff <= amp_ff[31] ? 32'(-amp_ff) : amp_ff;
      neg0_ff <= amp_ff[31];
      sq1_ff <= 64'(dm0_ff) * 64'(dm0_ff);
      neg1_ff <= neg0_ff; am1_ff <= am0_ff;
      pp00_ff <= 64'(sq1_ff[31:0]) * 64'(inv_ff[31:0]);
      pp01_ff <= 48'(sq1_ff[31:0]) * 48'(inv_ff[47:32]);
      pp10_ff <= 64'(sq1_ff[63:32]) * 64'(inv_ff[31:0]);
      pp11_ff <= 48'(sq1_ff[63:32]) * 48'(inv_ff[47:32]);
      neg2_ff <= neg1_ff; am2_ff <= am1_ff;
      prod3_ff <= prod3;
      neg3_ff <= neg2_ff; am3_ff <= am2_ff;
      // in range when the exponent is below 32.0
      ok4_ff <= e_full[113:37] == '0;
      e4_ff <= e_full[37:0];
      neg4_ff <= neg3_ff; am4_ff <= am3_ff;
      k5_ff <= kq; r5_ff <= kr[31:0]; ok5_ff <= ok4_ff;
      neg5_ff <= neg4_ff; am5_ff <= am4_ff;
      p_ff[0] <= 33'h1_0000_0000; r_ff[0] <= r5_ff; k_ff[0] <= k5_ff;
      ok_ff[0] <= ok5_ff; ng_ff[0] <= neg5_ff; am_ff[0] <= am5_ff;
   end

   // one Horner step per two stages: p = 1 - ((r*p)>>32)/n, n from TERMS down
   for (genvar g = 0; g < TERMS; g++) begin : g_horner
      logic [63:0] rp;
      logic [63:0] tq;
      logic [31:0] tdiv;
      localparam logic [3:0] N = 4'(TERMS - g);
      assign rp = 64'(r_ff[g]) * 64'(p_ff[g]);
      assign tq = 64'(t_ff[g]) * 64'(recip_n(N));
      // correct estimate: recip rounded up can overshoot by one
      assign tdiv = (36'(tq[63:32]) * 36'(N) > 36'(t_ff[g])) ? tq[63:32] - 32'd1 : tq[63:32];
      always_ff @(posedge clock) begin
         t_ff[g] <= rp[63:32];
         rh_ff[g] <= r_ff[g]; kh_ff[g] <= k_ff[g];
         okh_ff[g] <= ok_ff[g]; ngh_ff[g] <= ng_ff[g]; amh_ff[g] <= am_ff[g];
         p_ff[g+1] <= 33'h1_0000_0000 - 33'(tdiv);
         r_ff[g+1] <= rh_ff[g]; k_ff[g+1] <= kh_ff[g];
         ok_ff[g+1] <= okh_ff[g]; ng_ff[g+1] <= ngh_ff[g]; am_ff[g+1] <= amh_ff[g];
      end
   end

   // scale by amplitude, round, saturate
   logic [64:0] m_ff; logic [5:0] km_ff; logic okm_ff; logic ngm_ff;
   logic [6:0] sh;
   logic [64:0] mag;
   logic signed [31:0] val;
   logic sat;
   always_ff @(posedge clock) begin
      m_ff <= 65'(am_ff[TERMS]) * 65'(p_ff[TERMS]);
      km_ff <= k_ff[TERMS];
      okm_ff <= ok_ff[TERMS];
      ngm_ff <= ng_ff[TERMS];
   end
   always_comb begin
      sh = 7'd32 + 7'(km_ff);
      mag = (m_ff + (65'd1 << (sh - 7'd1))) >> sh;
      val = '0;
      sat = 1'b0;
      if (okm_ff && sh < 7'd64) begin
         if (ngm_ff) begin
            if (mag > 65'(MAXPOS) + 65'd1) begin
               sat = 1'b1; val = 32'(-(MAXPOS + 64'sd1));
            end else val = 32'(-mag);
         end else begin
            if (mag > 65'(MAXPOS)) begin
               sat = 1'b1; val = 32'(MAXPOS);
            end else val = 32'(mag);
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else rsp_valid <= v_ff[ST-1];
      rsp_gauss_value <= val;
      rsp_saturated <= sat;
   end
endmodule

### sv/gfe_checker.sv
// Port-level checker for the Gaussian evaluator, bound to the top level.
`include "gaussian_function_eval_assert.svh"
module gfe_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_saturated,
   input logic pready
);
   `GFE_ASSERT_IMPL(a_pready, clock, reset, 1'b1, pready)
   `GFE_ASSERT_IMPL(a_sat_only_valid, clock, reset, rsp_saturated, rsp_valid)
   `GFE_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)
   `GFE_ASSERT_IMPL(a_latency, clock, reset, start && !busy, ##33 rsp_valid)
endmodule

bind gaussian_function_eval gfe_checker u_gfe_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_saturated(rsp_saturated), .pready(pready)
);
